### design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;
  localparam int FUNC_W = 3;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_HEAD = 3'd0,
    FUNC_ADD_TAIL = 3'd1,
    FUNC_ADD_POS  = 3'd2,
    FUNC_REM_HEAD = 3'd3,
    FUNC_REM_TAIL = 3'd4,
    FUNC_REM_POS  = 3'd5
  } func_t;

  // Shift control for the cell row
  typedef struct packed {
    logic ins;  // open a slot at idx and write the value
    logic rem;  // close the slot at idx
  } cell_ctl_t;

endpackage

### design/ple_channels.sv
// ----------------------------------------------------------------------------
// ple_channels
// Valid/ready channel interfaces for request and result items.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::FUNC_W-1:0]        func;
  logic signed [ple_pkg::DATA_W-1:0] value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface ple_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [ple_pkg::DATA_W-1:0] removed_value;
  logic [ple_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, ok, removed_value, entry_count, input ready);
  modport sink   (input valid, ok, removed_value, entry_count, output ready);
endinterface

### design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with insert and remove at the
// head, the tail or a 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request items (func, value, position), valid/ready.
//   out_ch : one result item per request (ok, removed_value, entry_count).
//   A request is captured in an input register; the cell row then shifts in
//   parallel and the result register loads, once the result register is free
//   or being taken. out_ch.valid rises once the request has passed the input
//   register and the result register; one request per cycle is taken
//   sustained while out_ch.ready stays high, as the cell row updates in parallel.
//   Positions of 0 or 1 mean the head; an insert past the end appends and a
//   removal past the end takes the last entry. Insert into a full list or
//   removal from an empty one returns ok=0 and leaves the list unchanged.
//   Reset empties the list (count cleared; cell contents are not cleared).
//   When out_ch.ready is low the result holds, the input stage holds its
//   request once full, and in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  ple_in_if.sink           in_ch,
  ple_out_if.source        out_ch
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int DW = ple_pkg::DATA_W;

  // Input stage
  logic                       s1_valid_r;
  logic [ple_pkg::FUNC_W-1:0] s1_func_r;
  logic signed [DW-1:0]       s1_value_r;
  logic [ple_pkg::POS_W-1:0]  s1_position_r;

  // Result stage
  logic                       out_valid_r;
  logic                       out_ok_r;
  logic signed [DW-1:0]       out_removed_r;
  logic [ple_pkg::CNT_W-1:0]  out_count_r;

  // List count
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;

  logic                       adv;
  logic                       fire;
  logic                       is_ins;
  logic                       is_rem;
  logic                       full;
  logic                       empty;
  logic                       op_ok;
  logic [LW-1:0]              cnt_ext;
  logic [LW-1:0]              pos_ext;
  logic [LW-1:0]              pos_idx;
  logic [LW-1:0]              sel;
  logic [LW-1:0]              cnt_after;
  logic [IW-1:0]              idx;
  ple_pkg::cell_ctl_t         ctl;
  logic signed [DW-1:0]       rd_data;
  logic signed [DW-1:0]       removed;

  // Handshake
  assign adv         = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func_r     <= in_ch.func;
      s1_value_r    <= in_ch.value;
      s1_position_r <= in_ch.position;
    end
  end

  // Request decode and index clamp
  assign cnt_ext = LW'(count_r);
  assign pos_ext = LW'(s1_position_r);
  assign pos_idx = (pos_ext <= LW'(1)) ? '0 : pos_ext - LW'(1);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    sel    = '0;
    case (ple_pkg::func_t'(s1_func_r))
      ple_pkg::FUNC_ADD_HEAD: begin
        is_ins = 1'b1;
      end
      ple_pkg::FUNC_ADD_TAIL: begin
        is_ins = 1'b1;
        sel    = cnt_ext;
      end
      ple_pkg::FUNC_ADD_POS: begin
        is_ins = 1'b1;
        sel    = (pos_idx > cnt_ext) ? cnt_ext : pos_idx;
      end
      ple_pkg::FUNC_REM_HEAD: begin
        is_rem = 1'b1;
      end
      ple_pkg::FUNC_REM_TAIL: begin
        is_rem = 1'b1;
        sel    = cnt_ext - LW'(1);
      end
      ple_pkg::FUNC_REM_POS: begin
        is_rem = 1'b1;
        sel    = (pos_idx > cnt_ext - LW'(1)) ? cnt_ext - LW'(1) : pos_idx;
      end
      default: begin
        is_ins = 1'b0;
        is_rem = 1'b0;
      end
    endcase
  end

  // Index fits IW bits whenever the operation can succeed
  assign idx     = sel[IW-1:0];
  assign op_ok   = (is_ins && !full) || (is_rem && !empty);
  assign ctl.ins = fire && is_ins && !full;
  assign ctl.rem = fire && is_rem && !empty;
  assign removed = (is_rem && !empty) ? rd_data : '0;

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cell row
  ple_cells #(
    .CAPACITY (CAPACITY)
  ) u_cells (
    .clk      (clk),
    .ctl      (ctl),
    .idx      (idx),
    .wr_value (s1_value_r),
    .rd_data  (rd_data)
  );

  // Result register
  assign cnt_after = LW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ok_r      <= op_ok;
      out_removed_r <= removed;
      out_count_r   <= cnt_after[ple_pkg::CNT_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.entry_count   = out_count_r;

  // Checks
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(fire))
    else $error("count changed without a request");

  a_fire_result : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_removed_r == '0))
    else $error("failed request returned a nonzero value");

  a_single_op : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.rem))
    else $error("insert and remove in the same cycle");

endmodule

### design/ple_cells.sv
// ----------------------------------------------------------------------------
// ple_cells
// Row of list cells. Each cell holds, loads the new value, or takes its
// neighbor's value, from a compare of its index with idx.
// ----------------------------------------------------------------------------
module ple_cells #(
  parameter int CAPACITY = 64,
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                              clk,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic [IW-1:0]                     idx,
  input  logic signed [ple_pkg::DATA_W-1:0] wr_value,
  output logic signed [ple_pkg::DATA_W-1:0] rd_data
);

  logic signed [ple_pkg::DATA_W-1:0] cell_r [CAPACITY];

  // Entry at idx, taken before the shift
  assign rd_data = cell_r[idx];

  // Per-cell shift / hold
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.ins) begin
        if (IW'(i) == idx) begin
          cell_r[i] <= wr_value;
        end else if (IW'(i) > idx) begin
          if (i > 0) begin
            cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (ctl.rem) begin
        if ((IW'(i) >= idx) && (i < CAPACITY - 1)) begin
          cell_r[i] <= cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A scoreboard keeps
// its own copy of the list, works out the result of every accepted request
// and compares each result item with the oldest one pending. Both channels
// idle at random; the request mix swings between filling and draining so
// the list runs full and empty many times.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1530;
  localparam int BURST_LEN    = 100;
  localparam int MAX_IDLE     = 8;

  // Codes outside the defined request set; the block must answer ok=0
  localparam logic [ple_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [ple_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  // Request mix per burst
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  typedef struct {
    logic                              ok;
    logic signed [ple_pkg::DATA_W-1:0] removed;
    logic [ple_pkg::CNT_W-1:0]         cnt;
  } list_result_t;

  // Mirror of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [ple_pkg::DATA_W-1:0] cells [LIST_DEPTH];
    int unsigned                       held;
    logic signed [ple_pkg::DATA_W-1:0] last_taken;
    list_result_t                      pending [$];
    int                                errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // 1-based position to index; 0 and 1 both mean the head
    function int unsigned clamp_pos(logic [ple_pkg::POS_W-1:0] p, int unsigned top);
      int unsigned idx;
      idx = (p <= 1) ? 0 : p - 1;
      return (idx > top) ? top : idx;
    endfunction

    function bit insert_cell(int unsigned idx, logic signed [ple_pkg::DATA_W-1:0] v);
      if (held >= LIST_DEPTH) return 0;
      if (idx > held) idx = held;
      for (int unsigned i = held; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      held++;
      return 1;
    endfunction

    function bit remove_cell(int unsigned idx);
      if (held == 0) return 0;
      if (idx > held - 1) idx = held - 1;
      last_taken = cells[idx];
      for (int unsigned i = idx; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
      return 1;
    endfunction

    // Called on every accepted request item
    function void note_request(logic [ple_pkg::FUNC_W-1:0] f,
                               logic signed [ple_pkg::DATA_W-1:0] v,
                               logic [ple_pkg::POS_W-1:0] p);
      list_result_t r;
      bit           took;
      r.ok      = 0;
      r.removed = '0;
      took      = 0;
      case (f)
        ple_pkg::FUNC_ADD_HEAD: r.ok = insert_cell(0, v);
        ple_pkg::FUNC_ADD_TAIL: r.ok = insert_cell(held, v);
        ple_pkg::FUNC_ADD_POS:  r.ok = insert_cell(clamp_pos(p, held), v);
        ple_pkg::FUNC_REM_HEAD: begin
          r.ok = remove_cell(0);
          took = r.ok;
        end
        ple_pkg::FUNC_REM_TAIL: begin
          if (held != 0) r.ok = remove_cell(held - 1);
          took = r.ok;
        end
        ple_pkg::FUNC_REM_POS: begin
          if (held != 0) r.ok = remove_cell(clamp_pos(p, held - 1));
          took = r.ok;
        end
        default: r.ok = 0;
      endcase
      if (took) r.removed = last_taken;
      r.cnt = held[ple_pkg::CNT_W-1:0];
      pending.push_back(r);
    endfunction

    // Called on every accepted result item
    function void check_result(logic ok, logic signed [ple_pkg::DATA_W-1:0] removed,
                               logic [ple_pkg::CNT_W-1:0] cnt);
      list_result_t r;
      if (pending.size() == 0) begin
        $error("result item with no request pending");
        errors++;
        return;
      end
      r = pending.pop_front();
      if (ok !== r.ok) begin
        $error("ok: expected %0d, actual %0d", r.ok, ok);
        errors++;
      end
      if (removed !== r.removed) begin
        $error("removed_value: expected %0d, actual %0d", r.removed, removed);
        errors++;
      end
      if (cnt !== r.cnt) begin
        $error("entry_count: expected %0d, actual %0d", r.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  list_scoreboard sb = new();

  positional_list_engine #(.CAPACITY(LIST_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Drive one request item and wait for it to be taken
  task automatic send_request(logic [ple_pkg::FUNC_W-1:0] f,
                              logic signed [ple_pkg::DATA_W-1:0] v,
                              logic [ple_pkg::POS_W-1:0] p);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.value    <= v;
    in_ch.position <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(f, v, p);
  endtask

  // Stop sending until the block has answered everything
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // Result side: random stall, then take the next item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.ok, out_ch.removed_value, out_ch.entry_count);
    end
  end

  // Request side: reset, directed corners, then random bursts
  initial begin
    logic signed [ple_pkg::DATA_W-1:0] corner_vals [4];
    logic [ple_pkg::FUNC_W-1:0]        f;
    logic signed [ple_pkg::DATA_W-1:0] v;
    logic [ple_pkg::POS_W-1:0]         p;
    int                                mix;
    int                                ins_pct;
    int                                pick;

    corner_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};
    mix     = MIX_FILL;
    idle_on = 1'b1;

    in_ch.valid    <= 1'b0;
    in_ch.func     <= ple_pkg::FUNC_ADD_HEAD;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    rst_n          <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Removals and spare codes on an empty list
    send_request(ple_pkg::FUNC_REM_HEAD, 32'sh0, 7'd0);
    send_request(ple_pkg::FUNC_REM_TAIL, 32'sh0, 7'd0);
    send_request(ple_pkg::FUNC_REM_POS,  32'sh0, 7'd5);
    send_request(FUNC_SPARE_LO, 32'sh1234_5678, 7'd1);
    send_request(FUNC_SPARE_HI, 32'sh0, 7'd127);
    // Inserts: head, tail, head by position 0 and 1, middle, past the end
    send_request(ple_pkg::FUNC_ADD_HEAD, 32'sh7fff_ffff, 7'd0);
    send_request(ple_pkg::FUNC_ADD_TAIL, 32'sh8000_0000, 7'd0);
    send_request(ple_pkg::FUNC_ADD_POS,  32'sh0, 7'd0);
    send_request(ple_pkg::FUNC_ADD_POS,  -32'sh1, 7'd1);
    send_request(ple_pkg::FUNC_ADD_POS,  32'sh5555_aaaa, 7'd3);
    send_request(ple_pkg::FUNC_ADD_POS,  32'shaaaa_5555, 7'd127);
    send_request(ple_pkg::FUNC_ADD_POS,  32'sh0f0f_f0f0, 7'd7);
    send_request(FUNC_SPARE_LO, 32'sh0, 7'd2);
    // Removals: head by position 0 and 1, middle, past the end, tail, head
    send_request(ple_pkg::FUNC_REM_POS,  32'sh0, 7'd0);
    send_request(ple_pkg::FUNC_REM_POS,  32'sh0, 7'd1);
    send_request(ple_pkg::FUNC_REM_POS,  32'sh0, 7'd2);
    send_request(ple_pkg::FUNC_REM_POS,  32'sh0, 7'd127);
    send_request(ple_pkg::FUNC_REM_POS,  32'sh0, 7'd2);
    send_request(ple_pkg::FUNC_REM_TAIL, 32'sh0, 7'd0);
    send_request(ple_pkg::FUNC_REM_HEAD, 32'sh0, 7'd0);
    send_request(ple_pkg::FUNC_REM_HEAD, 32'sh0, 7'd0);

    // Random bursts; fill and drain bursts push the list to full and empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BURST_LEN == 0) begin
        mix     = (n / BURST_LEN) % 3;
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (n == 250 || $urandom_range(0, 199) == 0) hold_until_drained();

      ins_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
      pick    = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 3) begin
        f = (pick == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
      end else if ($urandom_range(0, 99) < ins_pct) begin
        f = (pick == 0) ? ple_pkg::FUNC_ADD_HEAD :
            (pick == 1) ? ple_pkg::FUNC_ADD_TAIL : ple_pkg::FUNC_ADD_POS;
      end else begin
        f = (pick == 0) ? ple_pkg::FUNC_REM_HEAD :
            (pick == 1) ? ple_pkg::FUNC_REM_TAIL : ple_pkg::FUNC_REM_POS;
      end

      v = ($urandom_range(0, 9) < 7) ? $urandom() : corner_vals[2'($urandom_range(0, 3))];

      // Mostly positions around the live range, sometimes anywhere in the field
      if ($urandom_range(0, 4) != 0) p = ple_pkg::POS_W'($urandom_range(0, sb.held + 2));
      else                           p = ple_pkg::POS_W'($urandom_range(0, 127));

      send_request(f, v, p);
    end
    in_ch.valid <= 1'b0;

    // Wait for the last results, then keep the clock running for strays
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
